// File: design/gspd_pkg.sv
// Shared types, constants and the duty guard helper function of the gain-scheduled PD steering unit.
package gspd_pkg;

  localparam int unsigned DUTY_CENTER = 685;
  localparam int unsigned DUTY_FULL   = 10000;
  localparam int unsigned DUTY_HIGH   = 770;
  localparam int unsigned DUTY_LOW    = 600;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DUTY_W = 14;

  // Serial MAC sizes: 16-bit operands, 33-bit signed accumulator
  localparam int unsigned MAC_OP_W  = 16;
  localparam int unsigned MAC_SH_W  = 32;
  localparam int unsigned MAC_ACC_W = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_GAIN_P_SLOPE = 3'd3,
    CFG_GAIN_P_LIMIT = 3'd4,
    CFG_ANGLE_LOW    = 3'd5,
    CFG_ANGLE_HIGH   = 3'd6,
    CFG_INC_MODE     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_ISSUE,
    ST_WAIT,
    ST_KPE,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_cmd_t;

  // Servo duty guards: out-of-range magnitude falls back to center, then clamp.
  function automatic logic [DUTY_W-1:0] duty_guard(input logic signed [16:0] d);
    logic signed [16:0] dd;
    logic [16:0]        a;
    dd = d;
    a  = d[16] ? 17'(-d) : 17'(d);
    if (a > 17'(DUTY_FULL)) begin
      dd = 17'(DUTY_CENTER);
      a  = 17'(DUTY_CENTER);
    end
    if (a > 17'(DUTY_HIGH)) begin
      dd = 17'(DUTY_HIGH);
      a  = 17'(DUTY_HIGH);
    end
    if (a < 17'(DUTY_LOW)) begin
      dd = 17'(DUTY_LOW);
    end
    return dd[DUTY_W-1:0];
  endfunction

endpackage

// File: design/gspd_div.sv
// Bit-serial restoring divider for the normalized coil position (L-R)*100/(L+R).
module gspd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [gspd_pkg::SAMPLE_W-1:0]      left_i,
  input  logic [gspd_pkg::SAMPLE_W-1:0]      right_i,
  output logic                               done_o,
  output logic signed [7:0]                  pos_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [18:0] rem_q, rem_d;
  logic [18:0] dsh_q, dsh_d;
  logic [6:0]  quo_q, quo_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;

  logic [11:0] diff;
  logic [12:0] sum;
  logic        ge;

  always_comb begin
    diff   = (left_i >= right_i) ? (left_i - right_i) : (right_i - left_i);
    sum    = {1'b0, left_i} + {1'b0, right_i};
    ge     = (rem_q >= dsh_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      // x100 = x64 + x32 + x4
      rem_d  = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
      dsh_d  = {sum, 6'b0};
      quo_d  = '0;
      neg_d  = (left_i < right_i);
      zero_d = (sum == '0);
      cnt_d  = 3'd6;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_q - dsh_q) : rem_q;
      quo_d = {quo_q[5:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign pos_o  = zero_q ? 8'sd0 : (neg_q ? 8'(-{1'b0, quo_q}) : 8'({1'b0, quo_q}));

endmodule

// File: design/gspd_mac.sv
// Bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle.
module gspd_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  gspd_pkg::mac_cmd_t                       cmd_i,
  input  logic [gspd_pkg::MAC_OP_W-1:0]            a_i,
  input  logic [gspd_pkg::MAC_OP_W-1:0]            b_i,
  output logic                                     busy_o,
  output logic signed [gspd_pkg::MAC_ACC_W-1:0]    acc_o
);

  logic                                   busy_q, busy_d;
  logic [gspd_pkg::MAC_SH_W-1:0]          a_sh_q, a_sh_d;
  logic [gspd_pkg::MAC_OP_W-1:0]          b_sh_q, b_sh_d;
  logic                                   neg_q, neg_d;
  logic signed [gspd_pkg::MAC_ACC_W-1:0]  acc_q, acc_d;
  logic signed [gspd_pkg::MAC_ACC_W-1:0]  addend;

  always_comb begin
    busy_d = busy_q;
    a_sh_d = a_sh_q;
    b_sh_d = b_sh_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    addend = {1'b0, a_sh_q};
    if (cmd_i.start) begin
      a_sh_d = {{(gspd_pkg::MAC_SH_W-gspd_pkg::MAC_OP_W){1'b0}}, a_i};
      b_sh_d = b_i;
      neg_d  = cmd_i.neg;
      busy_d = 1'b1;
      if (cmd_i.clear) begin
        acc_d = '0;
      end
    end else if (busy_q) begin
      if (b_sh_q[0]) begin
        acc_d = neg_q ? (acc_q - addend) : (acc_q + addend);
      end
      a_sh_d = a_sh_q << 1;
      b_sh_d = b_sh_q >> 1;
      // stop as soon as no multiplier bits remain
      if (b_sh_d == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sh_q <= a_sh_d;
    b_sh_q <= b_sh_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

// File: design/gain_scheduled_pd_steering_unit.sv
// Top level: sequencer, controller state and output register of the steering unit.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, samples, target... | to block
//  out     | out_valid_o/out_ready_i, pos/angle/duty   | from block
//  cfg     | cfg_valid_i/cfg_ready_o, index, data      | to block
//
// One item at a time: the serial divider, then serial MAC passes, each running over the bits
// of its multiplier; 4 passes and a gain step in positional mode, 3 passes in incremental
// mode, none for a held item. An item holds the input side until the final step has written
// the output register.
// Reset clears the controller history, the sequencer and the output valid.
// A new input transaction is taken while a finished result still waits downstream;
// the final step stalls only when the output register is still occupied.
module gain_scheduled_pd_steering_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [gspd_pkg::SAMPLE_W-1:0]         left_sample_i,
  input  logic [gspd_pkg::SAMPLE_W-1:0]         right_sample_i,
  input  logic signed [7:0]                     target_pos_i,
  input  logic signed [7:0]                     angle_offset_i,
  input  logic                                  hold_i,
  input  logic                                  run_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [7:0]                     measured_pos_o,
  output logic signed [7:0]                     steer_angle_o,
  output logic [gspd_pkg::DUTY_W-1:0]           pwm_duty_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [gspd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gspd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // configuration
  logic [15:0]       kp_q, ki_q, kd_q, jp_q, kpmax_q;
  logic signed [7:0] alow_q;
  logic [6:0]        ahigh_q;
  logic              inc_q;

  // sequencer and item data
  gspd_pkg::state_e  st_q, st_d;
  logic [1:0]        op_q, op_d;
  logic signed [7:0] tgt_q, ofs_q;
  logic              hold_q, run_q;
  logic signed [8:0] e_q, e_d;
  logic signed [9:0] d1_q, d1_d;
  logic signed [10:0] d2_q, d2_d;
  logic [15:0]       kpe_q, kpe_d;

  // controller history
  logic signed [8:0]  e1_q, e1_d, e2_q, e2_d;
  logic signed [15:0] ang_q, ang_d;

  // output register
  logic                        ov_q, ov_d;
  logic signed [7:0]           opos_q, opos_d, oang_q, oang_d;
  logic [gspd_pkg::DUTY_W-1:0] oduty_q, oduty_d;

  logic in_acc;
  logic div_done;
  logic signed [7:0] div_pos;
  gspd_pkg::mac_cmd_t mac_cmd;
  logic [15:0] mac_a, mac_b;
  logic mac_busy;
  logic signed [gspd_pkg::MAC_ACC_W-1:0] mac_acc;

  // datapath temporaries
  logic [8:0]  e_mag, d1_mag;
  logic [9:0]  d2_mag;
  logic [24:0] kp_sum;
  logic signed [24:0] t_val;
  logic signed [25:0] v_val;
  logic signed [16:0] ang_ext;
  logic signed [16:0] duty_in;
  logic signed [7:0]  ang_clamped;
  logic last_op;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == gspd_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  gspd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .left_i  (left_sample_i),
    .right_i (right_sample_i),
    .done_o  (div_done),
    .pos_o   (div_pos)
  );

  gspd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      jp_q    <= '0;
      kpmax_q <= '0;
      alow_q  <= -8'sd85;
      ahigh_q <= 7'd75;
      inc_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gspd_pkg::CFG_GAIN_P:       kp_q    <= cfg_data_i;
        gspd_pkg::CFG_GAIN_I:       ki_q    <= cfg_data_i;
        gspd_pkg::CFG_GAIN_D:       kd_q    <= cfg_data_i;
        gspd_pkg::CFG_GAIN_P_SLOPE: jp_q    <= cfg_data_i;
        gspd_pkg::CFG_GAIN_P_LIMIT: kpmax_q <= cfg_data_i;
        gspd_pkg::CFG_ANGLE_LOW:    alow_q  <= cfg_data_i[7:0];
        gspd_pkg::CFG_ANGLE_HIGH:   ahigh_q <= cfg_data_i[6:0];
        gspd_pkg::CFG_INC_MODE:     inc_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    e_mag  = e_q[8]  ? 9'(-e_q)   : 9'(e_q);
    d1_mag = d1_q[9] ? 9'(-d1_q)  : 9'(d1_q);
    d2_mag = d2_q[10] ? 10'(-d2_q) : 10'(d2_q);

    // MAC operand selection per pass
    mac_a = '0;
    mac_b = '0;
    mac_cmd.clear = 1'b0;
    mac_cmd.neg   = 1'b0;
    unique case ({inc_q, op_q})
      3'b000: begin
        mac_a = {7'b0, e_mag};
        mac_b = {7'b0, e_mag};
        mac_cmd.clear = 1'b1;
      end
      3'b001: begin
        mac_a = jp_q;
        mac_b = mac_acc[15:0];
        mac_cmd.clear = 1'b1;
      end
      3'b010: begin
        mac_a = kpe_q;
        mac_b = {7'b0, e_mag};
        mac_cmd.clear = 1'b1;
        mac_cmd.neg   = e_q[8];
      end
      3'b011: begin
        mac_a = kd_q;
        mac_b = {7'b0, d1_mag};
        mac_cmd.neg = d1_q[9];
      end
      3'b100: begin
        mac_a = kp_q;
        mac_b = {7'b0, d1_mag};
        mac_cmd.clear = 1'b1;
        mac_cmd.neg   = d1_q[9];
      end
      3'b101: begin
        mac_a = ki_q;
        mac_b = {7'b0, e_mag};
        mac_cmd.neg = e_q[8];
      end
      3'b110: begin
        mac_a = kd_q;
        mac_b = {6'b0, d2_mag};
        mac_cmd.neg = d2_q[10];
      end
      default: ;
    endcase
    mac_cmd.start = (st_q == gspd_pkg::ST_ISSUE);

    last_op = inc_q ? (op_q == 2'd2) : (op_q == 2'd3);

    // boosted proportional gain, capped
    kp_sum = {9'b0, kp_q} + {1'b0, mac_acc[31:8]};

    // Q25.8 to integer, truncated toward zero
    t_val = 25'(mac_acc >>> 8) + 25'((mac_acc < 0 && mac_acc[7:0] != 8'd0) ? 1 : 0);
    v_val = 26'(t_val) + (inc_q ? 26'(ang_q) : 26'sd0);

    // angle clamp: low limit first, high limit wins
    ang_ext = 17'(ang_q) + 17'(ofs_q);
    if (ang_ext < 17'(alow_q)) begin
      ang_ext = 17'(alow_q);
    end
    if (ang_ext > $signed({10'b0, ahigh_q})) begin
      ang_ext = $signed({10'b0, ahigh_q});
    end
    ang_clamped = ang_ext[7:0];
    duty_in = run_q ? (17'(gspd_pkg::DUTY_CENTER) - 17'(ang_clamped))
                    : 17'(gspd_pkg::DUTY_CENTER);

    st_d    = st_q;
    op_d    = op_q;
    e_d     = e_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    kpe_d   = kpe_q;
    e1_d    = e1_q;
    e2_d    = e2_q;
    ang_d   = ang_q;
    ov_d    = ov_q && !out_ready_i;
    opos_d  = opos_q;
    oang_d  = oang_q;
    oduty_d = oduty_q;

    unique case (st_q)
      gspd_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_d = gspd_pkg::ST_DIV;
        end
      end
      gspd_pkg::ST_DIV: begin
        if (div_done) begin
          st_d = gspd_pkg::ST_ERR;
        end
      end
      gspd_pkg::ST_ERR: begin
        e_d  = 9'(tgt_q) - 9'(div_pos);
        d1_d = 10'(e_d) - 10'(e1_q);
        d2_d = 11'(d1_d) - 11'(e1_q) + 11'(e2_q);
        op_d = 2'd0;
        st_d = hold_q ? gspd_pkg::ST_FIN : gspd_pkg::ST_ISSUE;
      end
      gspd_pkg::ST_ISSUE: begin
        st_d = gspd_pkg::ST_WAIT;
      end
      gspd_pkg::ST_WAIT: begin
        if (!mac_busy) begin
          if (!inc_q && op_q == 2'd1) begin
            st_d = gspd_pkg::ST_KPE;
          end else if (last_op) begin
            st_d = gspd_pkg::ST_ACC;
          end else begin
            op_d = op_q + 2'd1;
            st_d = gspd_pkg::ST_ISSUE;
          end
        end
      end
      gspd_pkg::ST_KPE: begin
        kpe_d = (kp_sum > {9'b0, kpmax_q}) ? kpmax_q : kp_sum[15:0];
        op_d  = 2'd2;
        st_d  = gspd_pkg::ST_ISSUE;
      end
      gspd_pkg::ST_ACC: begin
        if (v_val > 26'sd32767) begin
          ang_d = 16'sh7FFF;
        end else if (v_val < -26'sd32768) begin
          ang_d = 16'sh8000;
        end else begin
          ang_d = v_val[15:0];
        end
        e2_d = e1_q;
        e1_d = e_q;
        st_d = gspd_pkg::ST_FIN;
      end
      gspd_pkg::ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          opos_d  = div_pos;
          oang_d  = ang_clamped;
          oduty_d = gspd_pkg::duty_guard(duty_in);
          st_d    = gspd_pkg::ST_IDLE;
        end
      end
      default: st_d = gspd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= gspd_pkg::ST_IDLE;
      op_q  <= '0;
      ov_q  <= 1'b0;
      e1_q  <= '0;
      e2_q  <= '0;
      ang_q <= '0;
    end else begin
      st_q  <= st_d;
      op_q  <= op_d;
      ov_q  <= ov_d;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      ang_q <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q  <= target_pos_i;
      ofs_q  <= angle_offset_i;
      hold_q <= hold_i;
      run_q  <= run_i;
    end
    e_q     <= e_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    kpe_q   <= kpe_d;
    opos_q  <= opos_d;
    oang_q  <= oang_d;
    oduty_q <= oduty_d;
  end

  assign out_valid_o    = ov_q;
  assign measured_pos_o = opos_q;
  assign steer_angle_o  = oang_q;
  assign pwm_duty_o     = oduty_q;

endmodule

// File: dv/gain_scheduled_pd_steering_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the steering unit: queued stimulus, predictor and result checks.
module gain_scheduled_pd_steering_unit_test;

  typedef struct {
    logic [gspd_pkg::SAMPLE_W-1:0] left;
    logic [gspd_pkg::SAMPLE_W-1:0] right;
    logic signed [7:0]   target;
    logic signed [7:0]   offset;
    logic                hold;
    logic                run;
  } coil_item_t;

  typedef struct {
    logic signed [7:0]  pos;
    logic signed [7:0]  angle;
    logic [gspd_pkg::DUTY_W-1:0]  duty;
  } steer_result_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_ready_o;
  logic [gspd_pkg::SAMPLE_W-1:0]    left_sample_i  = '0;
  logic [gspd_pkg::SAMPLE_W-1:0]    right_sample_i = '0;
  logic signed [7:0]      target_pos_i   = '0;
  logic signed [7:0]      angle_offset_i = '0;
  logic                   hold_i         = 1'b0;
  logic                   run_i          = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i    = 1'b0;
  logic signed [7:0]      measured_pos_o;
  logic signed [7:0]      steer_angle_o;
  logic [gspd_pkg::DUTY_W-1:0]      pwm_duty_o;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [gspd_pkg::CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [gspd_pkg::CFG_DATA_W-1:0]  cfg_data_i     = '0;

  gain_scheduled_pd_steering_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .target_pos_i   (target_pos_i),
    .angle_offset_i (angle_offset_i),
    .hold_i         (hold_i),
    .run_i          (run_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .measured_pos_o (measured_pos_o),
    .steer_angle_o  (steer_angle_o),
    .pwm_duty_o     (pwm_duty_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register shadow, reset values
  logic [15:0]        p_gain    = '0;
  logic [15:0]        i_gain    = '0;
  logic [15:0]        d_gain    = '0;
  logic [15:0]        p_slope   = '0;
  logic [15:0]        p_ceiling = '0;
  logic signed [7:0]  ang_lo    = -8'sd85;
  logic [6:0]         ang_hi    = 7'd75;
  logic               incr_mode = 1'b0;

  // Controller history
  logic signed [8:0]  err_last  = '0;
  logic signed [8:0]  err_older = '0;
  logic signed [15:0] steer_acc = '0;

  coil_item_t    pending_q[$];
  steer_result_t expected_q[$];
  coil_item_t    drv_item;
  bit            in_taken = 1'b0;

  int src_idle_pct = 28;
  int snk_idle_pct = 28;
  int n_fail       = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_held       = 0;
  int n_incr       = 0;
  int n_settings   = 0;

  function automatic steer_result_t predict_steer(input coil_item_t it);
    longint l, r, pos, e, e1, s, boost, kpe, ang, duty, mag;
    steer_result_t res;
    l   = it.left;
    r   = it.right;
    pos = 0;
    if (l + r != 0) pos = ((l - r) * 100) / (l + r);
    if (!it.hold) begin
      e  = longint'(it.target) - pos;
      e1 = err_last;
      if (incr_mode) begin
        s = longint'(p_gain) * (e - e1) + longint'(i_gain) * e
          + longint'(d_gain) * (e - 2 * e1 + longint'(err_older));
        s = longint'(steer_acc) + s / 256;
      end else begin
        boost = (e * e * longint'(p_slope)) >> 8;
        kpe   = longint'(p_gain) + boost;
        if (kpe > longint'(p_ceiling)) kpe = p_ceiling;
        s = (kpe * e + longint'(d_gain) * (e - e1)) / 256;
      end
      if (s > 32767) s = 32767;
      else if (s < -32768) s = -32768;
      steer_acc = s[15:0];
      err_older = err_last;
      err_last  = e[8:0];
    end
    // low limit first, so a crossed pair ends on the high limit
    ang = longint'(steer_acc) + longint'(it.offset);
    if (ang < longint'(ang_lo)) ang = ang_lo;
    if (ang > longint'(ang_hi)) ang = ang_hi;
    duty = it.run ? (longint'(gspd_pkg::DUTY_CENTER) - ang)
                  : longint'(gspd_pkg::DUTY_CENTER);
    mag  = (duty < 0) ? -duty : duty;
    if (mag > longint'(gspd_pkg::DUTY_FULL)) begin
      duty = gspd_pkg::DUTY_CENTER;
      mag  = gspd_pkg::DUTY_CENTER;
    end
    if (mag > longint'(gspd_pkg::DUTY_HIGH)) begin
      duty = gspd_pkg::DUTY_HIGH;
      mag  = gspd_pkg::DUTY_HIGH;
    end
    if (mag < longint'(gspd_pkg::DUTY_LOW)) duty = gspd_pkg::DUTY_LOW;
    res.pos   = pos[7:0];
    res.angle = ang[7:0];
    res.duty  = duty[gspd_pkg::DUTY_W-1:0];
    return res;
  endfunction

  // Driver: presents queued items, holds each until its transaction completes
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item = pending_q.pop_front();
        left_sample_i  <= drv_item.left;
        right_sample_i <= drv_item.right;
        target_pos_i   <= drv_item.target;
        angle_offset_i <= drv_item.offset;
        hold_i         <= drv_item.hold;
        run_i          <= drv_item.run;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks results, predicts on each accepted input
  always @(posedge clk_i) begin : monitor
    steer_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: pos %0d angle %0d duty %0d",
                     measured_pos_o, steer_angle_o, pwm_duty_o);
        end else begin
          want = expected_q.pop_front();
          if (measured_pos_o !== want.pos || steer_angle_o !== want.angle ||
              pwm_duty_o !== want.duty) begin
            n_fail++;
            if (n_fail <= 10)
              $display("result %0d mismatch: expected pos %0d angle %0d duty %0d, got %0d %0d %0d",
                       n_checked, want.pos, want.angle, want.duty,
                       measured_pos_o, steer_angle_o, pwm_duty_o);
          end
          n_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(predict_steer(drv_item));
        in_taken = 1'b1;
        n_accepted++;
        if (drv_item.hold) n_held++;
        if (incr_mode) n_incr++;
      end
    end
  end

  task automatic write_reg(input gspd_pkg::cfg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gspd_pkg::CFG_GAIN_P:       p_gain    = data;
      gspd_pkg::CFG_GAIN_I:       i_gain    = data;
      gspd_pkg::CFG_GAIN_D:       d_gain    = data;
      gspd_pkg::CFG_GAIN_P_SLOPE: p_slope   = data;
      gspd_pkg::CFG_GAIN_P_LIMIT: p_ceiling = data;
      gspd_pkg::CFG_ANGLE_LOW:    ang_lo    = data[7:0];
      gspd_pkg::CFG_ANGLE_HIGH:   ang_hi    = data[6:0];
      gspd_pkg::CFG_INC_MODE:     incr_mode = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Unused upper data bits carry noise; the block must ignore them
  task automatic setup_regs(input logic [15:0] kp, ki, kd, jp, kmax,
                            input int lo, hi, input bit inc);
    write_reg(gspd_pkg::CFG_GAIN_P, kp);
    write_reg(gspd_pkg::CFG_GAIN_I, ki);
    write_reg(gspd_pkg::CFG_GAIN_D, kd);
    write_reg(gspd_pkg::CFG_GAIN_P_SLOPE, jp);
    write_reg(gspd_pkg::CFG_GAIN_P_LIMIT, kmax);
    write_reg(gspd_pkg::CFG_ANGLE_LOW, {8'($urandom), 8'(lo)});
    write_reg(gspd_pkg::CFG_ANGLE_HIGH, {9'($urandom), 7'(hi)});
    write_reg(gspd_pkg::CFG_INC_MODE, {15'($urandom), inc});
    n_settings++;
  endtask

  task automatic queue_item(input int l, r, t, o, input bit h, rn);
    coil_item_t it;
    it.left   = 12'(l);
    it.right  = 12'(r);
    it.target = 8'(t);
    it.offset = 8'(o);
    it.hold   = h;
    it.run    = rn;
    pending_q.push_back(it);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(16'h0100));
      4, 5:    return 16'($urandom_range(16'h0800));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(4095);
    endcase
  endfunction

  task automatic queue_random(input int n);
    int l, r, t, o;
    repeat (n) begin
      l = pick_sample();
      r = pick_sample();
      case ($urandom_range(9))
        0: begin l = 0; r = 0; end
        1: r = l;
        default: ;
      endcase
      t = ($urandom_range(9) < 7) ? int'($urandom_range(60)) - 30 : int'($urandom);
      o = ($urandom_range(9) < 6) ? int'($urandom_range(30)) - 15 : int'($urandom);
      queue_item(l, r, t, o, $urandom_range(99) < 12, $urandom_range(99) < 88);
    end
  endtask

  // Sender holds off until every outstanding result has been drained
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int lo, hi;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, zero gains: angle is just the clamped offset
    queue_item(0, 0, 0, 0, 1'b0, 1'b1);
    queue_item(4095, 0, 127, 127, 1'b0, 1'b1);
    queue_item(0, 4095, -128, -128, 1'b0, 1'b1);
    queue_item(4095, 4095, 0, 0, 1'b0, 1'b0);
    queue_item(1, 0, 0, 0, 1'b1, 1'b1);
    drain();

    // positional with boost reaching the ceiling, hold, run off
    setup_regs(16'h0300, 16'h0080, 16'h0200, 16'h0100, 16'h0600, -85, 75, 1'b0);
    queue_item(0, 4095, 127, 0, 1'b0, 1'b1);
    queue_item(4095, 0, -128, 0, 1'b0, 1'b1);
    queue_item(2000, 1000, 10, 5, 1'b0, 1'b1);
    queue_item(2000, 1000, 10, 5, 1'b1, 1'b1);
    queue_item(100, 300, 0, 0, 1'b0, 1'b0);
    drain();
    write_reg(gspd_pkg::CFG_INC_MODE, 16'h0001);
    queue_item(3000, 1000, 0, 0, 1'b0, 1'b1);
    queue_item(1000, 3000, 20, 0, 1'b0, 1'b1);
    queue_item(500, 500, -5, 0, 1'b1, 1'b1);
    queue_item(500, 500, -5, 0, 1'b0, 1'b1);
    drain();

    // full-scale gains and widest limits: accumulator saturation, duty guards
    setup_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -128, 127, 1'b1);
    queue_item(0, 4095, 127, 127, 1'b0, 1'b1);
    queue_item(0, 4095, 127, 127, 1'b0, 1'b1);
    queue_item(4095, 0, -128, -128, 1'b0, 1'b1);
    drain();
    write_reg(gspd_pkg::CFG_INC_MODE, 16'h0000);
    queue_item(4095, 0, -128, -128, 1'b0, 1'b1);
    queue_item(0, 4095, 127, 0, 1'b1, 1'b0);
    drain();

    // crossed limits: high limit wins
    setup_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 20, 5, 1'b0);
    queue_item(1000, 1000, 0, -100, 1'b0, 1'b1);
    queue_item(1000, 1000, 0, 100, 1'b0, 1'b1);
    drain();
    setup_regs(16'h0100, 16'h0000, 16'h0080, 16'h0000, 16'hFFFF, 0, 0, 1'b0);
    queue_item(1000, 2000, 50, 50, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(3))
        0:       lo = -128;
        1:       lo = 0;
        default: lo = -int'($urandom_range(128));
      endcase
      case ($urandom_range(3))
        0:       hi = 127;
        1:       hi = 0;
        default: hi = $urandom_range(127);
      endcase
      setup_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                 lo, hi, 1'($urandom));
      // one phase runs both sides flat out
      src_idle_pct = (ph == 4) ? 0 : 28;
      snk_idle_pct = (ph == 4) ? 0 : 28;
      queue_random(105);
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("%0d items accepted (%0d held, %0d incremental), %0d results checked",
             n_accepted, n_held, n_incr, n_checked);
    $display("%0d register settings, %0d mismatches", n_settings, n_fail);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd5_000_000);
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/gspd_pkg.sv
design/gspd_div.sv
design/gspd_mac.sv
design/gain_scheduled_pd_steering_unit.sv
dv/gain_scheduled_pd_steering_unit_test.sv
